FILE: design/csrt_pkg.sv
// ============================================================================
// csrt_pkg: shared types and constants of the cache slot replacement table
// Sizes, result codes, transfer payloads and the min-scan beat.
// ============================================================================
package csrt_pkg;

	localparam int ENTRIES    = 16;
	localparam int TAG_BITS   = 32;
	localparam int STAMP_BITS = 32;
	localparam int IDX_BITS   = $clog2(ENTRIES);
	localparam int CNT_BITS   = $clog2(ENTRIES + 1);
	localparam int ACT_BITS   = 3;

	localparam logic [ACT_BITS-1:0] ACT_NONE       = 3'd0;
	localparam logic [ACT_BITS-1:0] ACT_APPEND     = 3'd1;
	localparam logic [ACT_BITS-1:0] ACT_OLDEST     = 3'd2;
	localparam logic [ACT_BITS-1:0] ACT_STALE_REPL = 3'd3;
	localparam logic [ACT_BITS-1:0] ACT_STALE_DEL  = 3'd4;
	localparam logic [ACT_BITS-1:0] ACT_BAD        = 3'd5;

	typedef struct packed {
		logic [TAG_BITS-1:0] entry_tag;
		logic                cache_required;
		logic                stale_valid;
		logic [IDX_BITS-1:0] stale_index;
	} req_item_t;

	typedef struct packed {
		logic [ACT_BITS-1:0] action;
		logic [IDX_BITS-1:0] slot;
		logic [TAG_BITS-1:0] evicted_tag;
		logic [IDX_BITS-1:0] moved_from;
		logic [CNT_BITS-1:0] entry_count;
	} rsp_item_t;

	typedef struct packed {
		logic [TAG_BITS-1:0]   tag;
		logic [STAMP_BITS-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic                  valid;
		logic                  first;
		logic [IDX_BITS-1:0]   idx;
		logic [STAMP_BITS-1:0] stamp;
		logic [TAG_BITS-1:0]   tag;
	} scan_beat_t;

endpackage

FILE: design/csrt_min_scan.sv
// ============================================================================
// csrt_min_scan: running minimum over a stream of table entries
// Takes one entry per beat and keeps the slot with the lowest stamp.
// ============================================================================
module csrt_min_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  csrt_pkg::scan_beat_t          beat,
	output logic [csrt_pkg::IDX_BITS-1:0] best_idx,
	output logic [csrt_pkg::TAG_BITS-1:0] best_tag
);
	import csrt_pkg::*;

	logic [IDX_BITS-1:0]   best_idx_q;
	logic [STAMP_BITS-1:0] best_stamp_q;
	logic [TAG_BITS-1:0]   best_tag_q;
	logic                  take;

	// Strict less-than keeps the lowest slot on a tie.
	assign take = beat.valid && (beat.first || (beat.stamp < best_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_idx_q <= '0;
		end else if (take) begin
			best_idx_q <= beat.idx;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_stamp_q <= beat.stamp;
			best_tag_q   <= beat.tag;
		end
	end

	assign best_idx = best_idx_q;
	assign best_tag = best_tag_q;

endmodule

FILE: design/cache_slot_replacement_table_core.sv
// ============================================================================
// cache_slot_replacement_table_core: insertion-ordered replacement table
// Stores object tags with order stamps in one synchronous memory and
// replaces the oldest entry when full.
// ============================================================================
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------
//  req     | in        | req_valid / req_ready  | csrt_pkg::req_item_t
//  rsp     | out       | rsp_valid / rsp_ready  | csrt_pkg::rsp_item_t
//
// One item is processed at a time; req_ready is high only while idle.
// Append, reject and not-stored go straight to S_FIN; stale replace passes S_RD1;
// stale delete passes S_RD1 and S_RD2. Replacing the oldest entry passes S_SCAN and
// S_WR: the min scan reads one memory entry per cycle through the single read port.
// After reset the table is empty and no clearing pass is needed.
// A stalled rsp holds the finished result; the next one waits in the sequencer.
module cache_slot_replacement_table_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  csrt_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output csrt_pkg::rsp_item_t rsp
);
	import csrt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1  = 3'd1;
	localparam logic [2:0] S_RD2  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	entry_t mem [ENTRIES];

	logic [2:0]            state_q, state_d;
	logic [CNT_BITS-1:0]   count_q;
	logic [STAMP_BITS-1:0] order_q;
	logic [CNT_BITS-1:0]   scan_cnt_q;
	logic                  rsp_valid_q;
	req_item_t             item_q;
	rsp_item_t             res_q, res_d;
	rsp_item_t             fin_rsp;
	rsp_item_t             rsp_q;
	entry_t                rd_data_q;

	logic                  rd_en, wr_en, stamp_wr;
	logic [IDX_BITS-1:0]   rd_addr, wr_addr;
	entry_t                wr_data;
	logic                  req_fire, full, bad_idx, res_load;
	logic [IDX_BITS-1:0]   last_idx;
	scan_beat_t            beat;
	logic [IDX_BITS-1:0]   best_idx;
	logic [TAG_BITS-1:0]   best_tag;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign full      = (count_q == CNT_BITS'(ENTRIES));
	assign bad_idx   = CNT_BITS'(req.stale_index) >= count_q;
	assign last_idx  = IDX_BITS'(count_q - CNT_BITS'(1));

	assign beat.valid = (state_q == S_SCAN);
	assign beat.first = (scan_cnt_q == CNT_BITS'(1));
	assign beat.idx   = IDX_BITS'(scan_cnt_q - CNT_BITS'(1));
	assign beat.stamp = rd_data_q.stamp;
	assign beat.tag   = rd_data_q.tag;

	csrt_min_scan u_min_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat     (beat),
		.best_idx (best_idx),
		.best_tag (best_tag)
	);

	always_comb begin
		fin_rsp             = res_q;
		fin_rsp.entry_count = count_q;
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		stamp_wr = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		res_d    = res_q;
		res_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					res_load = 1'b1;
					res_d    = '0;
					if (req.stale_valid) begin
						res_d.slot = req.stale_index;
						if (bad_idx) begin
							res_d.action = ACT_BAD;
							state_d      = S_FIN;
						end else begin
							rd_en   = 1'b1;
							rd_addr = req.stale_index;
							state_d = S_RD1;
						end
					end else if (req.cache_required) begin
						if (full) begin
							rd_en   = 1'b1;
							rd_addr = '0;
							state_d = S_SCAN;
						end else begin
							wr_en         = 1'b1;
							stamp_wr      = 1'b1;
							wr_addr       = IDX_BITS'(count_q);
							wr_data.tag   = req.entry_tag;
							wr_data.stamp = order_q;
							res_d.action  = ACT_APPEND;
							res_d.slot    = IDX_BITS'(count_q);
							state_d       = S_FIN;
						end
					end else begin
						res_d.action = ACT_NONE;
						state_d      = S_FIN;
					end
				end
			end
			S_RD1: begin
				res_load          = 1'b1;
				res_d.evicted_tag = rd_data_q.tag;
				if (item_q.cache_required) begin
					wr_en         = 1'b1;
					stamp_wr      = 1'b1;
					wr_addr       = item_q.stale_index;
					wr_data.tag   = item_q.entry_tag;
					wr_data.stamp = order_q;
					res_d.action  = ACT_STALE_REPL;
					state_d       = S_FIN;
				end else begin
					rd_en   = 1'b1;
					rd_addr = last_idx;
					state_d = S_RD2;
				end
			end
			S_RD2: begin
				// Move the last valid entry, stamp included, into the freed slot.
				wr_en            = 1'b1;
				wr_addr          = item_q.stale_index;
				wr_data          = rd_data_q;
				res_load         = 1'b1;
				res_d.action     = ACT_STALE_DEL;
				res_d.moved_from = last_idx;
				state_d          = S_FIN;
			end
			S_SCAN: begin
				if (scan_cnt_q < CNT_BITS'(ENTRIES)) begin
					rd_en   = 1'b1;
					rd_addr = IDX_BITS'(scan_cnt_q);
				end else begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				wr_en             = 1'b1;
				stamp_wr          = 1'b1;
				wr_addr           = best_idx;
				wr_data.tag       = item_q.entry_tag;
				wr_data.stamp     = order_q;
				res_load          = 1'b1;
				res_d.action      = ACT_OLDEST;
				res_d.slot        = best_idx;
				res_d.evicted_tag = best_tag;
				state_d           = S_FIN;
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (req_fire) begin
			item_q <= req;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if ((state_q == S_FIN) && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= fin_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			order_q     <= '0;
			scan_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (stamp_wr) begin
				order_q <= order_q + STAMP_BITS'(1);
			end
			if ((state_q == S_IDLE) && req_fire && !req.stale_valid &&
			    req.cache_required && !full) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (state_q == S_RD2) begin
				count_q <= count_q - CNT_BITS'(1);
			end
			if (req_fire) begin
				scan_cnt_q <= CNT_BITS'(1);
			end else if ((state_q == S_SCAN) && (scan_cnt_q < CNT_BITS'(ENTRIES))) begin
				scan_cnt_q <= scan_cnt_q + CNT_BITS'(1);
			end
			if ((state_q == S_FIN) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: design/csrt_check.sv
// ============================================================================
// csrt_check: port-level checks of the cache slot replacement table
// Watches the top-level ports and flags results that break the table rules.
// ============================================================================
module csrt_check (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input csrt_pkg::req_item_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input csrt_pkg::rsp_item_t rsp
);
	import csrt_pkg::*;

	// The table never reports more entries than it has slots.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.entry_count <= CNT_BITS'(ENTRIES)))
		else $error("entry_count exceeds table size");

	// A not-stored result (ACT_NONE) carries no slot, tag or move.
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.action == ACT_NONE)) |->
		((rsp.slot == '0) && (rsp.evicted_tag == '0) && (rsp.moved_from == '0)))
		else $error("not-stored result has nonzero fields");

	// Only a delete reports a moved entry.
	a_moved_only_del: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.action != ACT_STALE_DEL)) |-> (rsp.moved_from == '0))
		else $error("moved_from set outside a delete");

	// An append fills the slot just past the previous last entry.
	a_append_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.action == ACT_APPEND)) |->
		(rsp.entry_count == CNT_BITS'(rsp.slot) + CNT_BITS'(1)))
		else $error("append slot does not match entry_count");

	// The block works on one item at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while a transfer is in progress");

endmodule

bind cache_slot_replacement_table_core csrt_check u_csrt_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
